// ===== sv/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the binary heap priority queue
// Entry layout, operation and status codes, sequencer states and sizes.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY    = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int TAG_WIDTH   = 16;
    localparam int ADDR_WIDTH  = $clog2(CAPACITY);
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
    localparam int CHILD_WIDTH = COUNT_WIDTH + 1;
    localparam int MODE_WIDTH  = 2;

    // Bit positions inside the order mode register.
    localparam int MODE_SIGNED_BIT  = 0;
    localparam int MODE_REVERSE_BIT = 1;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_WIDTH-1:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_PEEK = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_TOP,
        ST_LAST,
        ST_DN_CHK,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_DONE
    } state_t;

endpackage

// ===== sv/bmhq_store.sv =====
// ----------------------------------------------------------------------------
// bmhq_store: heap entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmhq_store
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [bmhq_pkg::ADDR_WIDTH-1:0] wr_addr,
    input  bmhq_pkg::entry_t             wr_data,
    input  logic [bmhq_pkg::ADDR_WIDTH-1:0] rd_addr,
    output bmhq_pkg::entry_t             rd_data
);

    bmhq_pkg::entry_t mem [bmhq_pkg::CAPACITY];
    bmhq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bmhq_cmp.sv =====
// ----------------------------------------------------------------------------
// bmhq_cmp: shared key order unit
// Tells whether key a orders strictly before key b under the order mode.
// ----------------------------------------------------------------------------
module bmhq_cmp
(
    input  logic [bmhq_pkg::KEY_WIDTH-1:0]  a_key,
    input  logic [bmhq_pkg::KEY_WIDTH-1:0]  b_key,
    input  logic [bmhq_pkg::MODE_WIDTH-1:0] mode,
    output logic                            precedes
);

    logic [bmhq_pkg::KEY_WIDTH-1:0] sign_flip;
    logic [bmhq_pkg::KEY_WIDTH-1:0] a_adj;
    logic [bmhq_pkg::KEY_WIDTH-1:0] b_adj;

    // Flipping the sign bit turns a signed compare into an unsigned one.
    always_comb
    begin
        sign_flip = '0;
        sign_flip[bmhq_pkg::KEY_WIDTH-1] = mode[bmhq_pkg::MODE_SIGNED_BIT];
        a_adj = a_key ^ sign_flip;
        b_adj = b_key ^ sign_flip;
        if (mode[bmhq_pkg::MODE_REVERSE_BIT])
        begin
            precedes = (b_adj < a_adj);
        end
        else
        begin
            precedes = (a_adj < b_adj);
        end
    end

endmodule

// ===== sv/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue: array-based binary heap priority queue
// Push, pop top and peek top on a heap of up to 256 key and tag entries.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one operation per
// transaction: func selects push, pop or peek; key and tag are the pushed
// entry. The output channel (out_valid, out_stall) returns one result per
// operation: the top entry for pop and peek, a status and the entry count.
// cfg_wr_en writes cfg_wr_data into the order mode register (signed keys,
// reversed order); write it only while no operation is in flight.
// One operation is worked at a time and in_stall stays high until its result
// is loaded into the output register. The sift loop shares one memory read
// port and one key comparator.
// A new transaction can be accepted while a result still waits on a stalled
// output; the next result then waits in the sequencer until the output frees.
// Reset empties the heap and clears the order mode; memory is not cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] key,
    input  logic [15:0] tag,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_key,
    output logic [15:0] out_tag,
    output logic [1:0]  status,
    output logic [8:0]  count
);

    localparam int AW = bmhq_pkg::ADDR_WIDTH;
    localparam int CW = bmhq_pkg::COUNT_WIDTH;
    localparam int HW = bmhq_pkg::CHILD_WIDTH;

    bmhq_pkg::state_t  state_reg, state_next;
    bmhq_pkg::func_t   func_reg, func_next;
    bmhq_pkg::entry_t  cur_reg, cur_next;
    bmhq_pkg::entry_t  sel_reg, sel_next;
    bmhq_pkg::status_t res_status_reg, res_status_next;
    bmhq_pkg::entry_t  res_entry_reg, res_entry_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [HW-1:0]     child_reg, child_next;
    logic [bmhq_pkg::MODE_WIDTH-1:0] mode_reg;

    logic              out_valid_reg;
    bmhq_pkg::entry_t  out_entry_reg;
    bmhq_pkg::status_t out_status_reg;
    logic [CW-1:0]     out_count_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    bmhq_pkg::entry_t  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    bmhq_pkg::entry_t  mem_rdata;

    logic [bmhq_pkg::KEY_WIDTH-1:0] cmp_a;
    logic [bmhq_pkg::KEY_WIDTH-1:0] cmp_b;
    logic              cmp_before;

    logic              accept;
    logic              out_free;
    logic              heap_full;
    logic              heap_empty;
    logic              pos_root;
    logic [CW-1:0]     pos_dec;
    logic [CW-1:0]     cnt_dec;
    logic [HW-1:0]     child_calc;
    logic [HW-1:0]     child_dec;
    logic [HW-1:0]     cnt_wide;
    bmhq_pkg::func_t   in_func;

    assign in_stall   = (state_reg != bmhq_pkg::ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_func    = bmhq_pkg::func_t'(func);
    assign heap_full  = (cnt_reg == CW'(bmhq_pkg::CAPACITY));
    assign heap_empty = (cnt_reg == '0);
    assign pos_root   = (pos_reg == CW'(1));
    assign pos_dec    = pos_reg - CW'(1);
    assign cnt_dec    = cnt_reg - CW'(1);
    assign child_calc = {pos_reg, 1'b0};
    assign child_dec  = child_calc - HW'(1);
    assign cnt_wide   = {1'b0, cnt_reg};

    bmhq_store u_store
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Operand selection for the single comparator.
    always_comb
    begin
        unique case (state_reg)
            bmhq_pkg::ST_DN_R:
            begin
                cmp_a = mem_rdata.key;
                cmp_b = sel_reg.key;
            end
            bmhq_pkg::ST_DN_CMP:
            begin
                cmp_a = sel_reg.key;
                cmp_b = cur_reg.key;
            end
            default:
            begin
                cmp_a = cur_reg.key;
                cmp_b = mem_rdata.key;
            end
        endcase
    end

    bmhq_cmp u_cmp
    (
        .a_key    (cmp_a),
        .b_key    (cmp_b),
        .mode     (mode_reg),
        .precedes (cmp_before)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmhq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        bmhq_pkg::FUNC_PUSH:
                        begin
                            state_next = heap_full ? bmhq_pkg::ST_DONE
                                                   : bmhq_pkg::ST_UP_CHK;
                        end
                        bmhq_pkg::FUNC_POP, bmhq_pkg::FUNC_PEEK:
                        begin
                            state_next = heap_empty ? bmhq_pkg::ST_DONE
                                                    : bmhq_pkg::ST_TOP;
                        end
                        default:
                        begin
                            state_next = bmhq_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bmhq_pkg::ST_UP_CHK:
            begin
                state_next = pos_root ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_UP_CMP;
            end
            bmhq_pkg::ST_UP_CMP:
            begin
                state_next = cmp_before ? bmhq_pkg::ST_UP_CHK : bmhq_pkg::ST_DONE;
            end
            bmhq_pkg::ST_TOP:
            begin
                if (func_reg == bmhq_pkg::FUNC_POP && cnt_reg != CW'(1))
                begin
                    state_next = bmhq_pkg::ST_LAST;
                end
                else
                begin
                    state_next = bmhq_pkg::ST_DONE;
                end
            end
            bmhq_pkg::ST_LAST:
            begin
                state_next = bmhq_pkg::ST_DN_CHK;
            end
            bmhq_pkg::ST_DN_CHK:
            begin
                state_next = (child_calc > cnt_wide) ? bmhq_pkg::ST_DONE
                                                     : bmhq_pkg::ST_DN_L;
            end
            bmhq_pkg::ST_DN_L:
            begin
                state_next = (child_reg < cnt_wide) ? bmhq_pkg::ST_DN_R
                                                    : bmhq_pkg::ST_DN_CMP;
            end
            bmhq_pkg::ST_DN_R:
            begin
                state_next = bmhq_pkg::ST_DN_CMP;
            end
            bmhq_pkg::ST_DN_CMP:
            begin
                state_next = cmp_before ? bmhq_pkg::ST_DN_CHK : bmhq_pkg::ST_DONE;
            end
            bmhq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bmhq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory control and datapath updates. The moving entry stays in cur_reg,
    // so each sift step writes only the entry that moves the other way.
    always_comb
    begin
        func_next       = func_reg;
        cur_next        = cur_reg;
        sel_next        = sel_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        child_next      = child_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_dec[AW-1:0];
        mem_wdata       = cur_reg;
        mem_raddr       = '0;
        unique case (state_reg)
            bmhq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next       = in_func;
                    cur_next.key    = key;
                    cur_next.tag    = tag;
                    res_entry_next  = '0;
                    res_status_next = bmhq_pkg::STATUS_OK;
                    unique case (in_func)
                        bmhq_pkg::FUNC_PUSH:
                        begin
                            if (heap_full)
                            begin
                                res_status_next = bmhq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CW'(1);
                                pos_next = cnt_reg + CW'(1);
                            end
                        end
                        bmhq_pkg::FUNC_POP, bmhq_pkg::FUNC_PEEK:
                        begin
                            if (heap_empty)
                            begin
                                res_status_next = bmhq_pkg::STATUS_EMPTY;
                            end
                        end
                        default:
                        begin
                            res_status_next = bmhq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            bmhq_pkg::ST_UP_CHK:
            begin
                if (pos_root)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_raddr = AW'((pos_reg >> 1) - CW'(1));
                end
            end
            bmhq_pkg::ST_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_before)
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg >> 1;
                end
            end
            bmhq_pkg::ST_TOP:
            begin
                res_entry_next = mem_rdata;
                if (func_reg == bmhq_pkg::FUNC_POP)
                begin
                    cnt_next  = cnt_dec;
                    mem_raddr = cnt_dec[AW-1:0];
                end
            end
            bmhq_pkg::ST_LAST:
            begin
                cur_next = mem_rdata;
                pos_next = CW'(1);
            end
            bmhq_pkg::ST_DN_CHK:
            begin
                if (child_calc > cnt_wide)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_raddr  = child_dec[AW-1:0];
                    child_next = child_calc;
                end
            end
            bmhq_pkg::ST_DN_L:
            begin
                sel_next  = mem_rdata;
                mem_raddr = child_reg[AW-1:0];
            end
            bmhq_pkg::ST_DN_R:
            begin
                // The right child wins only when it orders strictly first.
                if (cmp_before)
                begin
                    sel_next   = mem_rdata;
                    child_next = child_reg + HW'(1);
                end
            end
            bmhq_pkg::ST_DN_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_before)
                begin
                    mem_wdata = sel_reg;
                    pos_next  = child_reg[CW-1:0];
                end
            end
            bmhq_pkg::ST_DONE:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmhq_pkg::ST_IDLE;
            cnt_reg   <= '0;
            mode_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        cur_reg        <= cur_next;
        sel_reg        <= sel_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        pos_reg        <= pos_next;
        child_reg      <= child_next;
    end

    // Output register: loaded when a result is finished and the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == bmhq_pkg::ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bmhq_pkg::ST_DONE && out_free)
        begin
            out_entry_reg  <= res_entry_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_entry_reg.key;
    assign out_tag   = out_entry_reg.tag;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

endmodule

// ===== verif/binary_min_heap_queue_test.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_test: self-checking bench for the heap priority queue
// Drives push, pop, peek and unused operations through the valid/stall input
// channel and predicts every result with a behavioral heap of its own under
// all four order modes. Both channels idle at random. The heap is filled
// past capacity and emptied past zero, and the order mode is changed while
// entries are held.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_test;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam logic [1:0] ORDER_UMIN     = 2'd0;
    localparam logic [1:0] ORDER_SMIN     = 2'd1;
    localparam logic [1:0] ORDER_UMAX     = 2'd2;
    localparam logic [1:0] ORDER_SMAX     = 2'd3;
    localparam int         RANDOM_OPS     = 120;
    localparam int         SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] tag;
        logic [1:0]  status;
        logic [8:0]  count;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] key;
    logic [15:0] tag;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_key;
    logic [15:0] out_tag;
    logic [1:0]  status;
    logic [8:0]  count;

    // Behavioral copy of the heap, updated when each transaction is accepted.
    bmhq_pkg::entry_t heap_mem [bmhq_pkg::CAPACITY];
    int unsigned held;
    logic [1:0]  order_mode;

    result_t     expected_results [$];
    int          mismatches;
    int          ops_sent;
    int          pops_ok;
    int          pushes_refused;
    int          empty_reads;
    int          send_gap_pct;
    int          recv_stall_pct;

    binary_min_heap_queue uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (key),
        .tag         (tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_key     (out_key),
        .out_tag     (out_tag),
        .status      (status),
        .count       (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Negative when a comes first under the current order mode.
    function automatic int key_order(logic [31:0] a, logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        x = a;
        y = b;
        if (order_mode[bmhq_pkg::MODE_SIGNED_BIT])
        begin
            x[31] = ~x[31];
            y[31] = ~y[31];
        end
        if (order_mode[bmhq_pkg::MODE_REVERSE_BIT])
        begin
            x = b;
            y = a;
            if (order_mode[bmhq_pkg::MODE_SIGNED_BIT])
            begin
                x[31] = ~x[31];
                y[31] = ~y[31];
            end
        end
        if (x < y)
            return -1;
        if (x > y)
            return 1;
        return 0;
    endfunction

    function automatic void swap_entries(int unsigned i, int unsigned j);
        bmhq_pkg::entry_t held_entry;
        held_entry  = heap_mem[i];
        heap_mem[i] = heap_mem[j];
        heap_mem[j] = held_entry;
    endfunction

    // Applies one operation to the behavioral heap and returns its result.
    // Positions in the sift loops are 1-based.
    function automatic result_t heap_result(logic [1:0] op, logic [31:0] k,
                                            logic [15:0] t);
        result_t     r;
        int unsigned pos;
        int unsigned par;
        int unsigned child;
        r = '0;
        case (op)
            bmhq_pkg::FUNC_PUSH:
            begin
                if (held >= bmhq_pkg::CAPACITY)
                begin
                    r.status = bmhq_pkg::STATUS_FULL;
                end
                else
                begin
                    heap_mem[held].key = k;
                    heap_mem[held].tag = t;
                    held++;
                    pos = held;
                    while (pos > 1)
                    begin
                        par = pos >> 1;
                        if (key_order(heap_mem[pos-1].key, heap_mem[par-1].key) < 0)
                        begin
                            swap_entries(pos - 1, par - 1);
                            pos = par;
                        end
                        else
                            break;
                    end
                end
            end
            bmhq_pkg::FUNC_POP, bmhq_pkg::FUNC_PEEK:
            begin
                if (held == 0)
                begin
                    r.status = bmhq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    r.key = heap_mem[0].key;
                    r.tag = heap_mem[0].tag;
                    if (op == bmhq_pkg::FUNC_POP)
                    begin
                        held--;
                        if (held > 0)
                        begin
                            heap_mem[0] = heap_mem[held];
                            pos = 1;
                            while ((pos << 1) <= held)
                            begin
                                child = pos << 1;
                                if (child < held &&
                                    key_order(heap_mem[child-1].key,
                                              heap_mem[child].key) > 0)
                                    child++;
                                if (key_order(heap_mem[child-1].key,
                                              heap_mem[pos-1].key) < 0)
                                begin
                                    swap_entries(child - 1, pos - 1);
                                    pos = child;
                                end
                                else
                                    break;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = held[8:0];
        return r;
    endfunction

    // Presents one operation, holds it until accepted, then records the
    // expected result.
    task automatic send_op(logic [1:0] op, logic [31:0] k, logic [15:0] t);
        result_t r;
        @(negedge clk);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        tag      <= t;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        r = heap_result(op, k, t);
        expected_results.push_back(r);
        ops_sent++;
        if (op == bmhq_pkg::FUNC_POP && r.status == bmhq_pkg::STATUS_OK)
            pops_ok++;
        if (r.status == bmhq_pkg::STATUS_FULL)
            pushes_refused++;
        if (r.status == bmhq_pkg::STATUS_EMPTY)
            empty_reads++;
    endtask

    // Stops sending and waits until every outstanding result has arrived.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_order(logic [1:0] mode);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        order_mode   = mode;
    endtask

    // Keys lean toward ties, the sign boundary and the extremes.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 15);
            1:       return 32'h7FFF_FFF8 + $urandom_range(0, 15);
            2:       return $urandom_range(0, 1) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                                 : $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            send_op(FUNC_UNUSED, $urandom, 16'($urandom));
        else if (roll < 20)
            send_op(bmhq_pkg::FUNC_PEEK, $urandom, 16'($urandom));
        else if (roll < 55)
            send_op(bmhq_pkg::FUNC_POP, $urandom, 16'($urandom));
        else
            send_op(bmhq_pkg::FUNC_PUSH, pick_key(), 16'($urandom));
    endtask

    task automatic test_directed();
        set_order(ORDER_UMIN);
        send_op(bmhq_pkg::FUNC_POP, 32'h0, 16'h0);
        send_op(bmhq_pkg::FUNC_PEEK, 32'h0, 16'h0);
        send_op(FUNC_UNUSED, 32'h0, 16'h0);
        send_op(bmhq_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(bmhq_pkg::FUNC_PUSH, 32'h0000_0000, 16'h0000);
        send_op(bmhq_pkg::FUNC_PUSH, 32'h8000_0000, 16'hAAAA);
        send_op(bmhq_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 16'h5555);
        // Equal keys: the tags show which of the tied entries comes out first.
        send_op(bmhq_pkg::FUNC_PUSH, 32'd5, 16'd1);
        send_op(bmhq_pkg::FUNC_PUSH, 32'd5, 16'd2);
        send_op(bmhq_pkg::FUNC_PUSH, 32'd5, 16'd3);
        send_op(bmhq_pkg::FUNC_PEEK, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        repeat (7) send_op(bmhq_pkg::FUNC_POP, 32'h0, 16'h0);
        send_op(bmhq_pkg::FUNC_POP, 32'h0, 16'h0);
        set_order(ORDER_SMIN);
        send_op(bmhq_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 16'h0001);
        send_op(bmhq_pkg::FUNC_PUSH, 32'h8000_0000, 16'h0002);
        send_op(bmhq_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 16'h0003);
        send_op(bmhq_pkg::FUNC_PUSH, 32'h0000_0000, 16'h0004);
        repeat (4) send_op(bmhq_pkg::FUNC_POP, 32'h0, 16'h0);
    endtask

    // Fills the heap, pushes against a full heap, then empties it again.
    task automatic test_fill_and_empty(logic [1:0] mode);
        set_order(mode);
        repeat (bmhq_pkg::CAPACITY + 2)
            send_op(bmhq_pkg::FUNC_PUSH, pick_key(), 16'($urandom));
        send_op(bmhq_pkg::FUNC_PEEK, 32'h0, 16'h0);
        repeat (bmhq_pkg::CAPACITY + 1) send_op(bmhq_pkg::FUNC_POP, 32'h0, 16'h0);
    endtask

    task automatic test_random_mix(logic [1:0] mode);
        set_order(mode);
        repeat (RANDOM_OPS)
        begin
            send_random_op();
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    // The order changes under held entries, which stay where they are.
    task automatic test_order_change_held();
        set_order(ORDER_UMIN);
        repeat (12) send_op(bmhq_pkg::FUNC_PUSH, pick_key(), 16'($urandom));
        set_order(ORDER_SMAX);
        send_op(bmhq_pkg::FUNC_PEEK, 32'h0, 16'h0);
        repeat (6) send_op(bmhq_pkg::FUNC_POP, 32'h0, 16'h0);
        set_order(ORDER_SMIN);
        repeat (6) send_op(bmhq_pkg::FUNC_PUSH, pick_key(), 16'($urandom));
        repeat (13) send_op(bmhq_pkg::FUNC_POP, 32'h0, 16'h0);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: key %h tag %h status %0d count %0d",
                         $time, out_key, out_tag, status, count);
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_key !== exp_r.key)
                begin
                    $display("%0t: out_key expected %h actual %h", $time, exp_r.key, out_key);
                    mismatches++;
                end
                if (out_tag !== exp_r.tag)
                begin
                    $display("%0t: out_tag expected %h actual %h", $time, exp_r.tag, out_tag);
                    mismatches++;
                end
                if (status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             status);
                    mismatches++;
                end
                if (count !== exp_r.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, exp_r.count, count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 2'd0;
        in_valid       = 1'b0;
        func           = bmhq_pkg::FUNC_PUSH;
        key            = 32'h0;
        tag            = 16'h0;
        out_stall      = 1'b0;
        held           = 0;
        order_mode     = ORDER_UMIN;
        mismatches     = 0;
        ops_sent       = 0;
        pops_ok        = 0;
        pushes_refused = 0;
        empty_reads    = 0;
        send_gap_pct   = 37;
        recv_stall_pct = 62;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_and_empty(ORDER_UMAX);

        send_gap_pct   = 62;
        recv_stall_pct = 37;
        test_random_mix(ORDER_UMIN);
        test_random_mix(ORDER_SMIN);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_mix(ORDER_UMAX);
        test_random_mix(ORDER_SMAX);
        test_order_change_held();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d operations in all four order modes: %0d entries popped,",
                 ops_sent, pops_ok);
        $display("%0d pushes refused on a full heap, %0d reads of an empty heap.",
                 pushes_refused, empty_reads);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
